// ----- rtl/core/hsv_to_rgb565_core_macros.svh -----
// Assertion macros used by the port-level checker of the HSV to RGB565 core.
`ifndef HSV_TO_RGB565_CORE_MACROS_SVH
`define HSV_TO_RGB565_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define HSV565_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define HSV565_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/core/hsv565_pkg.sv -----
// Shared types and constants of the HSV to RGB565 core.
package hsv565_pkg;

  // Stream word widths, fields packed from the lowest bit up.
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 40;

  // Number of register stages from the input to the output register.
  localparam int unsigned PIPE_DEPTH = 7;

  // Reciprocal constants for division by constants (2^s / d, floored unless noted).
  localparam logic [10:0] RECIP60_S16  = 11'd1092;   // 1/60 with 16 fraction bits
  localparam logic [11:0] RECIP6_S14   = 12'd2731;   // 1/6 with 14 fraction bits (rounded up)
  localparam logic [16:0] RECIP60_S22  = 17'd69905;  // 1/60 with 22 fraction bits
  localparam logic [8:0]  RECIP255_S16 = 9'd257;     // 1/255 with 16 fraction bits

  // Hue sectors of 60 degrees, named after the dominant channel and the rising or falling one.
  typedef enum logic [2:0] {
    SEC_RED_UPG = 3'd0,
    SEC_GRN_DNR = 3'd1,
    SEC_GRN_UPB = 3'd2,
    SEC_BLU_DNG = 3'd3,
    SEC_BLU_UPR = 3'd4,
    SEC_RED_DNB = 3'd5
  } sector_e;

endpackage

// ----- rtl/core/hsv565_datapath.sv -----
// Seven-stage arithmetic pipeline of the HSV to RGB565 core.
module hsv565_datapath #(
  parameter int unsigned HUE_FRAC_BITS = 6
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [hsv565_pkg::S_TDATA_W-1:0] data_i,
  output logic [hsv565_pkg::M_TDATA_W-1:0] data_o
);
  import hsv565_pkg::*;

  localparam logic [15:0] SPAN      = 16'(60 << HUE_FRAC_BITS);
  localparam logic [15:0] FRAC_MASK = 16'((1 << HUE_FRAC_BITS) - 1);

  // Stage 1: hue integer part, coarse quotient by 60, chroma and offset terms.
  logic [14:0] hue_in, h_int;
  logic [7:0]  sat_in, val_in;
  logic [25:0] hq_prod;
  logic [14:0] s1_hue_q, s1_h_q;
  logic [9:0]  s1_q0_q;
  logic [15:0] s1_c_q, s1_m_q;
  logic [7:0]  s1_v_q;

  assign hue_in  = data_i[14:0];
  assign sat_in  = data_i[22:15];
  assign val_in  = data_i[30:23];
  assign h_int   = hue_in >> HUE_FRAC_BITS;
  assign hq_prod = 26'(h_int) * 26'(RECIP60_S16);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_hue_q <= hue_in;
      s1_h_q   <= h_int;
      s1_q0_q  <= hq_prod[25:16];
      s1_c_q   <= 16'(val_in) * 16'(sat_in);
      s1_m_q   <= 16'(val_in) * 16'(8'd255 - sat_in);
      s1_v_q   <= val_in;
    end
  end

  // Stage 2: exact sector count and offset within the sector; coarse low/255.
  logic [15:0] h_rem;
  logic        h_fix;
  logic [9:0]  qh;
  logic [15:0] rem_fixed, offs;
  logic [24:0] lq_prod;
  logic [9:0]  s2_qh_q;
  logic [15:0] s2_offs_q, s2_c_q, s2_m_q;
  logic [7:0]  s2_v_q, s2_lq0_q;

  assign h_rem     = 16'(s1_h_q) - 16'(s1_q0_q) * 16'd60;
  assign h_fix     = (h_rem >= 16'd60);
  assign qh        = h_fix ? s1_q0_q + 10'd1 : s1_q0_q;
  assign rem_fixed = h_fix ? h_rem - 16'd60 : h_rem;
  assign offs      = (rem_fixed << HUE_FRAC_BITS) | (16'(s1_hue_q) & FRAC_MASK);
  assign lq_prod   = 25'(s1_m_q) * 25'(RECIP255_S16);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_qh_q   <= qh;
      s2_offs_q <= offs;
      s2_c_q    <= s1_c_q;
      s2_m_q    <= s1_m_q;
      s2_v_q    <= s1_v_q;
      s2_lq0_q  <= lq_prod[23:16];
    end
  end

  // Stage 3: chroma times sector weight, sector count over six, minimum channel.
  logic [21:0] d_prod;
  logic [15:0] weight, l_rem;
  logic [7:0]  low;
  logic [9:0]  s3_qh_q;
  logic [6:0]  s3_d_q;
  logic [31:0] s3_prod_q;
  logic [15:0] s3_m_q;
  logic [7:0]  s3_v_q, s3_low_q;

  assign d_prod = 22'(s2_qh_q) * 22'(RECIP6_S14);
  assign weight = s2_qh_q[0] ? SPAN - s2_offs_q : s2_offs_q;
  assign l_rem  = s2_m_q - 16'(s2_lq0_q) * 16'd255;
  assign low    = (l_rem >= 16'd255) ? s2_lq0_q + 8'd1 : s2_lq0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_qh_q   <= s2_qh_q;
      s3_d_q    <= d_prod[20:14];
      s3_prod_q <= 32'(s2_c_q) * 32'(weight);
      s3_m_q    <= s2_m_q;
      s3_v_q    <= s2_v_q;
      s3_low_q  <= low;
    end
  end

  // Stage 4: sector number, scaled product and coarse quotient by 60.
  logic [9:0]  sect_full;
  logic [31:0] prod_shr;
  logic [21:0] t_val;
  logic [38:0] u_prod;
  logic [2:0]  s4_sect_q;
  logic [21:0] s4_t_q;
  logic [15:0] s4_u0_q, s4_m_q;
  logic [7:0]  s4_v_q, s4_low_q;

  assign sect_full = s3_qh_q - 10'(s3_d_q) * 10'd6;
  assign prod_shr  = s3_prod_q >> HUE_FRAC_BITS;
  assign t_val     = prod_shr[21:0];
  assign u_prod    = 39'(t_val) * 39'(RECIP60_S22);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_sect_q <= sect_full[2:0];
      s4_t_q    <= t_val;
      s4_u0_q   <= u_prod[37:22];
      s4_m_q    <= s3_m_q;
      s4_v_q    <= s3_v_q;
      s4_low_q  <= s3_low_q;
    end
  end

  // Stage 5: exact quotient by 60, added to the offset term.
  logic [21:0] u_rem;
  logic [15:0] u_val;
  logic [16:0] y_sum;
  logic [2:0]  s5_sect_q;
  logic [15:0] s5_y_q;
  logic [7:0]  s5_v_q, s5_low_q;

  assign u_rem = s4_t_q - 22'(s4_u0_q) * 22'd60;
  assign u_val = (u_rem >= 22'd60) ? s4_u0_q + 16'd1 : s4_u0_q;
  assign y_sum = 17'(s4_m_q) + 17'(u_val);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_sect_q <= s4_sect_q;
      s5_y_q    <= y_sum[15:0];
      s5_v_q    <= s4_v_q;
      s5_low_q  <= s4_low_q;
    end
  end

  // Stage 6: coarse quotient of the secondary channel by 255.
  logic [24:0] y_prod;
  logic [2:0]  s6_sect_q;
  logic [15:0] s6_y_q;
  logic [7:0]  s6_y0_q, s6_v_q, s6_low_q;

  assign y_prod = 25'(s5_y_q) * 25'(RECIP255_S16);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_sect_q <= s5_sect_q;
      s6_y_q    <= s5_y_q;
      s6_y0_q   <= y_prod[23:16];
      s6_v_q    <= s5_v_q;
      s6_low_q  <= s5_low_q;
    end
  end

  // Stage 7: secondary channel, channel routing by sector and RGB565 packing.
  logic [15:0] y_rem;
  logic [7:0]  mid, red, grn, blu;
  logic [7:0]  out_r_q, out_g_q, out_b_q;
  logic [15:0] out_p_q;

  assign y_rem = s6_y_q - 16'(s6_y0_q) * 16'd255;
  assign mid   = (y_rem >= 16'd255) ? s6_y0_q + 8'd1 : s6_y0_q;

  always_comb begin
    case (sector_e'(s6_sect_q))
      SEC_RED_UPG: begin red = s6_v_q;   grn = mid;      blu = s6_low_q; end
      SEC_GRN_DNR: begin red = mid;      grn = s6_v_q;   blu = s6_low_q; end
      SEC_GRN_UPB: begin red = s6_low_q; grn = s6_v_q;   blu = mid;      end
      SEC_BLU_DNG: begin red = s6_low_q; grn = mid;      blu = s6_v_q;   end
      SEC_BLU_UPR: begin red = mid;      grn = s6_low_q; blu = s6_v_q;   end
      default:     begin red = s6_v_q;   grn = s6_low_q; blu = mid;      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_r_q <= red;
      out_g_q <= grn;
      out_b_q <= blu;
      out_p_q <= {red[7:3], grn[7:2], blu[7:3]};
    end
  end

  assign data_o = {out_p_q, out_b_q, out_g_q, out_r_q};

endmodule

// ----- rtl/core/hsv_to_rgb565_core.sv -----
// Top level of the HSV to RGB565 core: stream handshake and valid pipeline.
// Throughput is one request per cycle unless the master side stalls; the seven
// register stages all advance together.
// A stall on the master side holds every stage and drops s_axis_tready at once.
// Reset (rst_ni low, asynchronous) clears the valid bits only; data registers keep
// whatever they hold, and no result is presented until a new request arrives.
module hsv_to_rgb565_core #(
  parameter int unsigned HUE_FRAC_BITS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Slave side. tdata: hue_sixtyfourths [14:0], saturation [22:15],
  // brightness [30:23], zero pad [31].
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [hsv565_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // Master side. tdata: red [7:0], green [15:8], blue [23:16], packed565 [39:24].
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [hsv565_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import hsv565_pkg::*;

  // One valid bit per register stage; bit PIPE_DEPTH-1 marks the output register.
  logic [PIPE_DEPTH-1:0] vld_q, vld_d;
  logic                  advance;

  // The pipeline moves whenever its output register is empty or being drained.
  // Bubbles in the middle simply travel along with the data.
  assign advance       = !vld_q[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = advance;
  assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];

  always_comb begin
    vld_d = vld_q;
    if (advance) begin
      vld_d = {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // The datapath registers share the same enable, so each request stays
  // aligned with its valid bit through all seven stages.
  hsv565_datapath #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .en_i   (advance),
    .data_i (s_axis_tdata),
    .data_o (m_axis_tdata)
  );

endmodule

// ----- rtl/core/hsv565_checker.sv -----
// Port-level assertions for the HSV to RGB565 core and their bind.
`include "hsv_to_rgb565_core_macros.svh"

module hsv565_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [hsv565_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [hsv565_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import hsv565_pkg::*;

  // A stalled result stays offered.
  `HSV565_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `HSV565_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")

  // The RGB565 word is the top bits of the three RGB888 channels.
  `HSV565_ASSERT(a_pack_match, m_axis_tvalid |-> (m_axis_tdata[39:35] == m_axis_tdata[7:3]) && (m_axis_tdata[34:29] == m_axis_tdata[15:10]) && (m_axis_tdata[28:24] == m_axis_tdata[23:19]), "RGB565 word disagrees with channels")

  // With an empty output register the core always takes a new request.
  `HSV565_ASSERT_ALWAYS(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "core stalled with empty output")

endmodule

bind hsv_to_rgb565_core hsv565_checker u_hsv565_checker (.*);

// ----- tb/sv/hsv_to_rgb565_checker.sv -----
// Checker for the HSV to RGB565 core: predicts every result and compares it on the master side.
`timescale 1ns / 100ps

module hsv_to_rgb565_checker #(
  parameter int unsigned HUE_FRAC_BITS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // tdata: hue_sixtyfourths [14:0], saturation [22:15], brightness [30:23], pad [31].
  input  logic [hsv565_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: red [7:0], green [15:8], blue [23:16], packed565 [39:24].
  input  logic [hsv565_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output int                               mismatch_count_o,
  output int                               pending_o
);
  import hsv565_pkg::*;

  localparam longint unsigned HUE_SPAN = 64'd60 << HUE_FRAC_BITS;

  typedef struct packed {
    logic [15:0] packed565;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } rgb_result_t;

  // Colors predicted for requests that have not come out yet, oldest first.
  rgb_result_t predicted_rgb_q[$];
  rgb_result_t got_rgb;
  rgb_result_t want_rgb;
  int unsigned result_index = 0;

  // Integer HSV to RGB conversion; the secondary channel is floored over 255 * span.
  function automatic rgb_result_t convert_hsv(input logic [S_TDATA_W-1:0] word);
    longint unsigned hue;
    longint unsigned sat;
    longint unsigned val;
    longint unsigned sector_num;
    longint unsigned offs;
    longint unsigned weight;
    logic [7:0]      top_ch;
    logic [7:0]      low_ch;
    logic [7:0]      mid_ch;
    sector_e         sector;
    rgb_result_t     res;
    hue        = word[14:0];
    sat        = word[22:15];
    val        = word[30:23];
    // Hues past 360 degrees wrap by sector; the offset inside the sector is kept.
    sector_num = (hue / HUE_SPAN) % 6;
    offs       = hue % HUE_SPAN;
    weight     = (sector_num & 1) ? (HUE_SPAN - offs) : offs;
    sector     = sector_e'(sector_num[2:0]);
    top_ch     = val[7:0];
    low_ch     = 8'((val * (255 - sat)) / 255);
    mid_ch     = 8'((val * sat * weight + val * (255 - sat) * HUE_SPAN) / (255 * HUE_SPAN));
    case (sector)
      SEC_RED_UPG: begin
        res.red = top_ch; res.green = mid_ch; res.blue = low_ch;
      end
      SEC_GRN_DNR: begin
        res.red = mid_ch; res.green = top_ch; res.blue = low_ch;
      end
      SEC_GRN_UPB: begin
        res.red = low_ch; res.green = top_ch; res.blue = mid_ch;
      end
      SEC_BLU_DNG: begin
        res.red = low_ch; res.green = mid_ch; res.blue = top_ch;
      end
      SEC_BLU_UPR: begin
        res.red = mid_ch; res.green = low_ch; res.blue = top_ch;
      end
      default: begin
        res.red = top_ch; res.green = low_ch; res.blue = mid_ch;
      end
    endcase
    res.packed565 = {res.red[7:3], res.green[7:2], res.blue[7:3]};
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count_o = mismatch_count_o + 1;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                                result_index, name, got, want));
    end
  endtask

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  // The master side is checked before the slave side, so a result can never
  // be matched against a request taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_rgb = m_axis_tdata[39:0];
        if (predicted_rgb_q.size() == 0) begin
          report_mismatch($sformatf("result 0x%0h with no request outstanding", got_rgb));
        end else begin
          want_rgb = predicted_rgb_q.pop_front();
          compare_field("red", 16'(got_rgb.red), 16'(want_rgb.red));
          compare_field("green", 16'(got_rgb.green), 16'(want_rgb.green));
          compare_field("blue", 16'(got_rgb.blue), 16'(want_rgb.blue));
          compare_field("packed565", got_rgb.packed565, want_rgb.packed565);
        end
        result_index++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_rgb_q.push_back(convert_hsv(s_axis_tdata));
      end
      pending_o = predicted_rgb_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the HSV to RGB565 core testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import hsv565_pkg::*;

  localparam int unsigned HUE_FRAC_BITS   = 6;
  localparam int unsigned HUE_SPAN        = 60 << HUE_FRAC_BITS;
  localparam int unsigned HUE_LEGAL_MAX   = 23039;
  localparam int unsigned HUE_FIELD_MAX   = 32767;
  localparam int          RANDOM_REQUESTS = 650;
  // Worst quiet stretch of a correct run is a sender gap plus a receiver
  // stall plus the pipeline, well under the watchdog limit.
  localparam int          WATCHDOG_LIMIT  = 400;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int mismatch_count;
  int pending_count;
  int quiet_cycles = 0;

  hsv_to_rgb565_core #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  hsv_to_rgb565_checker #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_rgb_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [S_TDATA_W-1:0] pack_hsv(input int unsigned hue,
                                                    input int unsigned sat,
                                                    input int unsigned val);
    return {1'b0, val[7:0], sat[7:0], hue[14:0]};
  endfunction

  // Saturation and brightness lean toward their extremes, where the
  // truncation and the grey case live.
  function automatic int unsigned random_fraction();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(1, 3);
      3:       return $urandom_range(252, 254);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Most hues are legal; some use the whole 15-bit field to exercise the wrap,
  // and some sit within two steps of a sector boundary.
  function automatic logic [S_TDATA_W-1:0] random_request();
    int unsigned hue;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      hue = $urandom_range(0, HUE_LEGAL_MAX);
    end else if (pick < 8) begin
      hue = $urandom_range(0, HUE_FIELD_MAX);
    end else begin
      hue = HUE_SPAN * $urandom_range(1, 8) - 2 + $urandom_range(0, 4);
    end
    return pack_hsv(hue, random_fraction(), random_fraction());
  endfunction

  // Presents one request after an idle gap and returns at the edge where it is
  // taken. With no gap, tvalid simply stays high into the next request.
  task automatic send_request(input logic [S_TDATA_W-1:0] word, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sender: a directed set first, then random requests. Idle gaps are drawn
  // per request, with stretches of back-to-back traffic mixed in.
  initial begin
    logic [S_TDATA_W-1:0] directed_q[$];
    bit                   calm;
    int                   gap;
    calm          = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;

    // Fully saturated primaries and secondaries at the start of each sector.
    for (int k = 0; k < 6; k++) begin
      directed_q.push_back(pack_hsv(k * HUE_SPAN, 255, 255));
    end
    // Last offsets of a rising and a falling sector.
    directed_q.push_back(pack_hsv(HUE_SPAN - 1, 255, 255));
    directed_q.push_back(pack_hsv(2 * HUE_SPAN - 1, 200, 230));
    // Highest legal hue, and hues past 360 degrees that wrap around.
    directed_q.push_back(pack_hsv(HUE_LEGAL_MAX, 255, 255));
    directed_q.push_back(pack_hsv(6 * HUE_SPAN, 255, 255));
    directed_q.push_back(pack_hsv(7 * HUE_SPAN + 100, 180, 240));
    directed_q.push_back(pack_hsv(HUE_FIELD_MAX, 255, 255));
    // Zero saturation gives grey at the value.
    directed_q.push_back(pack_hsv(5000, 0, 200));
    directed_q.push_back(pack_hsv(12345, 0, 255));
    // Black with full saturation, and everything at zero.
    directed_q.push_back(pack_hsv(9000, 255, 0));
    directed_q.push_back(pack_hsv(0, 0, 0));
    // Smallest nonzero fractions, and mid-sector at half strength.
    directed_q.push_back(pack_hsv(1, 1, 1));
    directed_q.push_back(pack_hsv(HUE_SPAN / 2, 128, 128));
    directed_q.push_back(pack_hsv(5 * HUE_SPAN, 255, 1));
    directed_q.push_back(pack_hsv(4 * HUE_SPAN - 1, 1, 255));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) begin
      send_request(directed_q[i], (i % 4 == 3) ? $urandom_range(0, 17) : 0);
    end
    repeat (RANDOM_REQUESTS) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 17);
      send_request(random_request(), gap);
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker settle on the last request before looking at the count,
    // then give the pipeline time to show any result nobody asked for.
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("hsv_to_rgb565_core regression: pass");
    end else begin
      $display("hsv_to_rgb565_core regression: fail");
    end
    $finish;
  end

  // Receiver: stalls a drawn number of cycles before taking each result, with
  // stretches of no stalling so the pipeline also runs full.
  initial begin
    bit calm;
    int stall;
    calm          = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog: ends the run when neither side has moved a request for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("hsv_to_rgb565_core regression: fail");
      $finish;
    end
  end

endmodule
